[rtl/rvx_pkg.sv]
// ----------------------------------------------------------------------------
// rvx_pkg
// shared types, constants and helpers for the rv64im subset execute unit
// ----------------------------------------------------------------------------
package rvx_pkg;

   localparam int XLEN     = 64;
   localparam int NUM_REGS = 32;

   // stream payload layout
   localparam int REQ_DATA_W = 160;
   localparam int INS_LSB    = 64;
   localparam int LDAT_LSB   = 96;
   localparam int RSP_DATA_W = 264;
   localparam int RSP_PAD_W  = 3;

   // major opcodes
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_IMM32  = 7'h1b;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_OP32   = 7'h3b;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // funct3 codes
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_MUL  = 3'd0;
   localparam logic [2:0] F3_DIV  = 3'd4;
   localparam logic [2:0] F3_DIVU = 3'd5;
   localparam logic [2:0] F3_REM  = 3'd6;
   localparam logic [2:0] F3_REMU = 3'd7;
   localparam logic [2:0] F3_LWU  = 3'd6;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // funct7 / top6 codes
   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [5:0] T6_LOGIC  = 6'h00;
   localparam logic [5:0] T6_ARITH  = 6'h10;

   localparam logic [31:0] EBREAK_INSN = 32'h0010_0073;
   localparam logic [4:0]  REG_A0      = 5'd10;

   // result codes
   localparam logic       KIND_RETIRE   = 1'b0;
   localparam logic       KIND_LOAD_REQ = 1'b1;
   localparam logic       OP_INSN       = 1'b0;
   localparam logic       OP_LOAD_RESP  = 1'b1;
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_EBREAK     = 2'd1;
   localparam logic [1:0] ST_ILLEGAL    = 2'd2;
   localparam logic [1:0] ST_NO_LOAD    = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } md_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

   function automatic logic [XLEN-1:0] sext32(input logic [31:0] v);
      sext32 = {{(XLEN-32){v[31]}}, v};
   endfunction

endpackage

[rtl/rv64im_subset_execute_unit.sv]
// ----------------------------------------------------------------------------
// rv64im_subset_execute_unit
// executes rv64im subset instructions against a register file in memory
// ----------------------------------------------------------------------------
// flow: accept + register read, execute, retire; mul/mulw and divide/remainder
//   also wait on the multiply/divide unit, which produces one quotient bit a cycle
// throughput: one transaction at a time, set by the register file read-execute-
//   write chain and the shared multiply/divide unit
// reset: synchronous; register file reads as zero and no load is pending
module rv64im_subset_execute_unit #(
   parameter int XLEN     = rvx_pkg::XLEN,
   parameter int NUM_REGS = rvx_pkg::NUM_REGS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rvx_pkg::REQ_DATA_W-1:0] req_tdata,  // pc, instruction, load_data
   input  logic                           req_tuser,  // operation
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // next_pc, mem_addr, mem_size_log2, store_enable, store_data, status, trap_value
   output logic [rvx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser   // kind
);
   import rvx_pkg::*;

   localparam int AW = $clog2(NUM_REGS);

   state_type state_ff, state_in;

   logic            accept, out_free, rf_wr_en;
   logic            op_ff;
   logic [XLEN-1:0] pc_ff, ldat_ff;
   logic [31:0]     ins_ff;
   logic [XLEN-1:0] a, b;

   // pending load
   logic            ld_pend_ff, ld_pend_in, ld_sgn_ff, ld_sgn_in;
   logic [AW-1:0]   ld_rd_ff, ld_rd_in;
   logic [1:0]      ld_size_ff, ld_size_in;
   logic [XLEN-1:0] ld_pc_ff, ld_pc_in;

   // retire result
   logic            res_kind_ff, res_kind_in, res_sten_ff, res_sten_in;
   logic [XLEN-1:0] res_npc_ff, res_npc_in, res_addr_ff, res_addr_in;
   logic [XLEN-1:0] res_sdata_ff, res_sdata_in;
   logic [1:0]      res_size_ff, res_size_in, res_st_ff, res_st_in;
   logic            wb_en_ff, wb_en_in;
   logic [AW-1:0]   wb_rd_ff, wb_rd_in;
   logic [XLEN-1:0] wb_val_ff, wb_val_in;
   logic [XLEN-1:0] a0_ff, a0_in;

   // muldiv post-processing
   logic            md_word_ff, md_rem_ff, md_neg_ff, md_dz_ff, md_mul_ff;
   logic            md_word_in, md_rem_in, md_neg_in, md_dz_in, md_mul_in;
   logic [XLEN-1:0] md_a_ff, md_a_in;

   logic                  rsp_valid_ff, rsp_valid_in, rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   md_ctrl_type     md_ctrl;
   md_stat_type     md_stat;
   logic [XLEN-1:0] md_opa, md_opb, md_prod, md_quo, md_rem;
   logic [XLEN-1:0] md_raw, md_fix, md_res;

   // execute-stage decode
   logic [6:0]      opc, f7;
   logic [2:0]      f3;
   logic [5:0]      top6;
   logic [XLEN-1:0] ii, imm_s, imm_b, imm_j, imm_u, pc4;
   logic [31:0]     sra_w, sra_wi;
   logic            e_kind, e_sten, e_wr, e_md, e_bad, e_ld, e_taken;
   logic [XLEN-1:0] e_npc, e_addr, e_sdata, e_val, l_val;
   logic [1:0]      e_size, e_st;
   logic            sgn_w, na, nb;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rf_wr_en   = (state_ff == S_DONE) && out_free && wb_en_ff;

   rvx_regfile #(
      .XLEN     (XLEN),
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_tdata[INS_LSB+15 +: AW]),
      .rd_addr_b (req_tdata[INS_LSB+20 +: AW]),
      .rd_data_a (a),
      .rd_data_b (b),
      .wr_en     (rf_wr_en),
      .wr_addr   (wb_rd_ff),
      .wr_data   (wb_val_ff)
   );

   rvx_muldiv #(
      .XLEN (XLEN)
   ) u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (md_ctrl),
      .opa       (md_opa),
      .opb       (md_opb),
      .stat      (md_stat),
      .product   (md_prod),
      .quotient  (md_quo),
      .remainder (md_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = (e_md && op_ff == OP_INSN) ? S_WAIT : S_DONE;
         end
         S_WAIT: begin
            if (md_stat.done) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // instruction decode and combinational execution
   always_comb begin
      opc    = ins_ff[6:0];
      f3     = ins_ff[14:12];
      f7     = ins_ff[31:25];
      top6   = ins_ff[31:26];
      ii     = {{(XLEN-12){ins_ff[31]}}, ins_ff[31:20]};
      imm_s  = {{(XLEN-12){ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
      imm_b  = {{(XLEN-13){ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25],
                ins_ff[11:8], 1'b0};
      imm_j  = {{(XLEN-21){ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20],
                ins_ff[30:21], 1'b0};
      imm_u  = sext32({ins_ff[31:12], 12'b0});
      pc4    = pc_ff + XLEN'(4);
      sra_w  = $signed(a[31:0]) >>> b[4:0];
      sra_wi = $signed(a[31:0]) >>> ins_ff[24:20];

      e_kind  = KIND_RETIRE;
      e_npc   = pc4;
      e_addr  = '0;
      e_size  = '0;
      e_sten  = 1'b0;
      e_sdata = '0;
      e_st    = ST_OK;
      e_wr    = 1'b0;
      e_val   = '0;
      e_md    = 1'b0;
      e_bad   = 1'b0;
      e_ld    = 1'b0;
      e_taken = 1'b0;

      case (opc)
         OPC_OP: begin
            e_wr = 1'b1;
            if (f7 == F7_BASE && f3 == F3_ADD) e_val = a + b;
            else if (f7 == F7_BASE && f3 == F3_SLT)
               e_val = XLEN'($signed(a) < $signed(b));
            else if (f7 == F7_BASE && f3 == F3_SLTU) e_val = XLEN'(a < b);
            else if (f7 == F7_BASE && f3 == F3_XOR) e_val = a ^ b;
            else if (f7 == F7_BASE && f3 == F3_OR) e_val = a | b;
            else if (f7 == F7_BASE && f3 == F3_AND) e_val = a & b;
            else if (f7 == F7_ALT && f3 == F3_ADD) e_val = a - b;
            else if (f7 == F7_MULDIV && (f3 == F3_MUL || f3 == F3_DIVU || f3 == F3_REMU))
               e_md = 1'b1;
            else e_bad = 1'b1;
         end
         OPC_OP32: begin
            e_wr = 1'b1;
            if (f7 == F7_BASE && f3 == F3_ADD) e_val = sext32(a[31:0] + b[31:0]);
            else if (f7 == F7_BASE && f3 == F3_SLL) e_val = sext32(a[31:0] << b[4:0]);
            else if (f7 == F7_BASE && f3 == F3_SR) e_val = sext32(a[31:0] >> b[4:0]);
            else if (f7 == F7_ALT && f3 == F3_ADD) e_val = sext32(a[31:0] - b[31:0]);
            else if (f7 == F7_ALT && f3 == F3_SR) e_val = sext32(sra_w);
            else if (f7 == F7_MULDIV && (f3 == F3_MUL || f3[2])) e_md = 1'b1;
            else e_bad = 1'b1;
         end
         OPC_OP_IMM: begin
            e_wr = 1'b1;
            if (f3 == F3_ADD) e_val = a + ii;
            else if (f3 == F3_SLTU) e_val = XLEN'(a < ii);
            else if (f3 == F3_XOR) e_val = a ^ ii;
            else if (f3 == F3_OR) e_val = a | ii;
            else if (f3 == F3_AND) e_val = a & ii;
            else if (f3 == F3_SLL && top6 == T6_LOGIC) e_val = a << ins_ff[25:20];
            else if (f3 == F3_SR && top6 == T6_LOGIC) e_val = a >> ins_ff[25:20];
            else if (f3 == F3_SR && top6 == T6_ARITH)
               e_val = $signed(a) >>> ins_ff[25:20];
            else e_bad = 1'b1;
         end
         OPC_IMM32: begin
            e_wr = 1'b1;
            if (f3 == F3_ADD) e_val = sext32(a[31:0] + ii[31:0]);
            else if (f3 == F3_SLL && f7 == F7_BASE)
               e_val = sext32(a[31:0] << ins_ff[24:20]);
            else if (f3 == F3_SR && top6 == T6_LOGIC)
               e_val = sext32(a[31:0] >> ins_ff[24:20]);
            else if (f3 == F3_SR && top6 == T6_ARITH) e_val = sext32(sra_wi);
            else e_bad = 1'b1;
         end
         OPC_LOAD: begin
            if (f3 >= F3_LWU) begin
               e_bad = 1'b1;
            end else begin
               e_kind = KIND_LOAD_REQ;
               e_npc  = '0;
               e_addr = a + ii;
               e_size = f3[1:0];
               e_ld   = 1'b1;
            end
         end
         OPC_STORE: begin
            if (f3[2]) begin
               e_bad = 1'b1;
            end else begin
               e_sten  = 1'b1;
               e_addr  = a + imm_s;
               e_size  = f3[1:0];
               e_sdata = b;
            end
         end
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ:  e_taken = (a == b);
               F3_BNE:  e_taken = (a != b);
               F3_BLT:  e_taken = ($signed(a) < $signed(b));
               F3_BGE:  e_taken = !($signed(a) < $signed(b));
               F3_BLTU: e_taken = (a < b);
               F3_BGEU: e_taken = (a >= b);
               default: e_bad = 1'b1;
            endcase
            if (e_taken) e_npc = pc_ff + imm_b;
         end
         OPC_AUIPC: begin
            e_wr  = 1'b1;
            e_val = pc_ff + imm_u;
         end
         OPC_LUI: begin
            e_wr  = 1'b1;
            e_val = imm_u;
         end
         OPC_JAL: begin
            e_wr  = 1'b1;
            e_val = pc4;
            e_npc = pc_ff + imm_j;
         end
         OPC_JALR: begin
            if (f3 != F3_ADD) begin
               e_bad = 1'b1;
            end else begin
               e_wr  = 1'b1;
               e_val = pc4;
               e_npc = (a + ii) & ~XLEN'(1);
            end
         end
         OPC_SYSTEM: begin
            if (ins_ff == EBREAK_INSN) e_st = ST_EBREAK;
            else e_bad = 1'b1;
         end
         default: e_bad = 1'b1;
      endcase

      if (e_bad) begin
         e_st    = ST_ILLEGAL;
         e_wr    = 1'b0;
         e_md    = 1'b0;
         e_ld    = 1'b0;
         e_kind  = KIND_RETIRE;
         e_addr  = '0;
         e_size  = '0;
         e_sten  = 1'b0;
         e_sdata = '0;
         e_npc   = pc4;
      end

      // muldiv operands: signed word forms divide magnitudes
      sgn_w = (opc == OPC_OP32) && (f3 == F3_DIV || f3 == F3_REM);
      na    = a[31];
      nb    = b[31];
      if (sgn_w) begin
         md_opa = XLEN'(na ? 32'(-a[31:0]) : a[31:0]);
         md_opb = XLEN'(nb ? 32'(-b[31:0]) : b[31:0]);
      end else if (opc == OPC_OP32) begin
         md_opa = XLEN'(a[31:0]);
         md_opb = XLEN'(b[31:0]);
      end else begin
         md_opa = a;
         md_opb = b;
      end

      // load response extension
      case (ld_size_ff)
         2'd0:    l_val = ld_sgn_ff ? {{(XLEN-8){ldat_ff[7]}}, ldat_ff[7:0]}
                                    : XLEN'(ldat_ff[7:0]);
         2'd1:    l_val = ld_sgn_ff ? {{(XLEN-16){ldat_ff[15]}}, ldat_ff[15:0]}
                                    : XLEN'(ldat_ff[15:0]);
         2'd2:    l_val = ld_sgn_ff ? sext32(ldat_ff[31:0]) : XLEN'(ldat_ff[31:0]);
         default: l_val = ldat_ff;
      endcase
   end

   assign md_ctrl.start  = (state_ff == S_EXEC) && (op_ff == OP_INSN) && e_md;
   assign md_ctrl.is_div = f3[2];

   always_comb begin
      md_raw = md_mul_ff ? md_prod : (md_rem_ff ? md_rem : md_quo);
      md_fix = (md_neg_ff && !md_mul_ff) ? XLEN'(-md_raw) : md_raw;
      if (md_dz_ff && !md_mul_ff) md_fix = md_rem_ff ? md_a_ff : '1;
      md_res = md_word_ff ? sext32(md_fix[31:0]) : md_fix;
   end

   // datapath register updates
   always_comb begin
      ld_pend_in   = ld_pend_ff;
      ld_rd_in     = ld_rd_ff;
      ld_size_in   = ld_size_ff;
      ld_sgn_in    = ld_sgn_ff;
      ld_pc_in     = ld_pc_ff;
      res_kind_in  = res_kind_ff;
      res_npc_in   = res_npc_ff;
      res_addr_in  = res_addr_ff;
      res_size_in  = res_size_ff;
      res_sten_in  = res_sten_ff;
      res_sdata_in = res_sdata_ff;
      res_st_in    = res_st_ff;
      wb_en_in     = wb_en_ff;
      wb_rd_in     = wb_rd_ff;
      wb_val_in    = wb_val_ff;
      a0_in        = a0_ff;
      md_word_in   = md_word_ff;
      md_rem_in    = md_rem_ff;
      md_neg_in    = md_neg_ff;
      md_dz_in     = md_dz_ff;
      md_mul_in    = md_mul_ff;
      md_a_in      = md_a_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      case (state_ff)
         S_EXEC: begin
            res_addr_in  = '0;
            res_size_in  = '0;
            res_sten_in  = 1'b0;
            res_sdata_in = '0;
            res_kind_in  = KIND_RETIRE;
            if (op_ff == OP_LOAD_RESP) begin
               wb_rd_in  = ld_rd_ff;
               wb_val_in = l_val;
               if (ld_pend_ff) begin
                  res_st_in  = ST_OK;
                  res_npc_in = ld_pc_ff;
                  wb_en_in   = 1'b1;
                  ld_pend_in = 1'b0;
               end else begin
                  res_st_in  = ST_NO_LOAD;
                  res_npc_in = '0;
                  wb_en_in   = 1'b0;
               end
            end else begin
               res_kind_in  = e_kind;
               res_npc_in   = e_npc;
               res_addr_in  = e_addr;
               res_size_in  = e_size;
               res_sten_in  = e_sten;
               res_sdata_in = e_sdata;
               res_st_in    = e_st;
               wb_en_in     = e_wr;
               wb_rd_in     = ins_ff[7 +: AW];
               wb_val_in    = e_val;
               ld_pend_in   = e_ld;
               if (e_ld) begin
                  ld_rd_in   = ins_ff[7 +: AW];
                  ld_size_in = f3[1:0];
                  ld_sgn_in  = !f3[2];
                  ld_pc_in   = pc4;
               end
               md_word_in = (opc == OPC_OP32);
               md_rem_in  = f3[1];
               md_mul_in  = !f3[2];
               md_neg_in  = sgn_w && (f3[1] ? na : (na ^ nb));
               md_dz_in   = (opc == OPC_OP32) ? (b[31:0] == '0) : (b == '0);
               md_a_in    = a;
            end
         end
         S_WAIT: begin
            if (md_stat.done) wb_val_in = md_res;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_kind_ff;
               rsp_data_in  = {{RSP_PAD_W{1'b0}},
                               (res_st_ff != ST_OK) ? a0_ff : XLEN'(0),
                               res_st_ff, res_sdata_ff, res_sten_ff,
                               res_size_ff, res_addr_ff, res_npc_ff};
               if (wb_en_ff && wb_rd_ff == AW'(REG_A0)) a0_in = wb_val_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ld_pend_ff   <= 1'b0;
         ld_rd_ff     <= '0;
         ld_size_ff   <= '0;
         ld_sgn_ff    <= 1'b0;
         ld_pc_ff     <= '0;
         a0_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ld_pend_ff   <= ld_pend_in;
         ld_rd_ff     <= ld_rd_in;
         ld_size_ff   <= ld_size_in;
         ld_sgn_ff    <= ld_sgn_in;
         ld_pc_ff     <= ld_pc_in;
         a0_ff        <= a0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         op_ff   <= req_tuser;
         pc_ff   <= req_tdata[XLEN-1:0];
         ins_ff  <= req_tdata[INS_LSB +: 32];
         ldat_ff <= req_tdata[LDAT_LSB +: XLEN];
      end
      res_kind_ff  <= res_kind_in;
      res_npc_ff   <= res_npc_in;
      res_addr_ff  <= res_addr_in;
      res_size_ff  <= res_size_in;
      res_sten_ff  <= res_sten_in;
      res_sdata_ff <= res_sdata_in;
      res_st_ff    <= res_st_in;
      wb_en_ff     <= wb_en_in;
      wb_rd_ff     <= wb_rd_in;
      wb_val_ff    <= wb_val_in;
      md_word_ff   <= md_word_in;
      md_rem_ff    <= md_rem_in;
      md_neg_ff    <= md_neg_in;
      md_dz_ff     <= md_dz_in;
      md_mul_ff    <= md_mul_in;
      md_a_ff      <= md_a_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("new transaction accepted while one is in flight");

   a_md_start_exec: assert property (@(posedge clock) disable iff (reset)
      md_ctrl.start |-> (state_ff == S_EXEC && !md_stat.busy))
      else $error("muldiv started outside execute or while busy");

   a_md_done_wait: assert property (@(posedge clock) disable iff (reset)
      md_stat.done |-> state_ff == S_WAIT)
      else $error("muldiv finished with nobody waiting");

   a_rf_write_free: assert property (@(posedge clock) disable iff (reset)
      rf_wr_en |=> rsp_tvalid)
      else $error("register write retired without a response");

endmodule

[rtl/rvx_regfile.sv]
// ----------------------------------------------------------------------------
// rvx_regfile
// integer register file: synchronous memory, two registered reads, one write
// ----------------------------------------------------------------------------
module rvx_regfile #(
   parameter int XLEN     = rvx_pkg::XLEN,
   parameter int NUM_REGS = rvx_pkg::NUM_REGS,
   localparam int AW      = $clog2(NUM_REGS)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr_a,
   input  logic [AW-1:0]   rd_addr_b,
   output logic [XLEN-1:0] rd_data_a,
   output logic [XLEN-1:0] rd_data_b,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [XLEN-1:0] wr_data
);
   import rvx_pkg::*;

   logic [XLEN-1:0]     regs_mem [NUM_REGS];
   logic [NUM_REGS-1:0] vld_ff;
   logic [XLEN-1:0]     data_a_ff, data_b_ff;
   logic                hit_a_ff, hit_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr != '0) begin
         regs_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_a_ff <= regs_mem[rd_addr_a];
         data_b_ff <= regs_mem[rd_addr_b];
      end
   end

   // entries never written read as zero, x0 always zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else begin
         if (wr_en && wr_addr != '0) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_a_ff <= vld_ff[rd_addr_a] && rd_addr_a != '0;
            hit_b_ff <= vld_ff[rd_addr_b] && rd_addr_b != '0;
         end
      end
   end

   assign rd_data_a = hit_a_ff ? data_a_ff : '0;
   assign rd_data_b = hit_b_ff ? data_b_ff : '0;

endmodule

[rtl/rvx_muldiv.sv]
// ----------------------------------------------------------------------------
// rvx_muldiv
// multi-cycle multiplier (four half-width steps) and restoring divider
// ----------------------------------------------------------------------------
module rvx_muldiv #(
   parameter int XLEN = rvx_pkg::XLEN
) (
   input  logic                clock,
   input  logic                reset,
   input  rvx_pkg::md_ctrl_type ctrl,
   input  logic [XLEN-1:0]     opa,
   input  logic [XLEN-1:0]     opb,
   output rvx_pkg::md_stat_type stat,
   output logic [XLEN-1:0]     product,
   output logic [XLEN-1:0]     quotient,
   output logic [XLEN-1:0]     remainder
);
   import rvx_pkg::*;

   localparam int HW = XLEN / 2;
   localparam int CW = $clog2(XLEN);

   logic            run_ff, run_in, div_ff, div_in, done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [XLEN-1:0] a_ff, a_in, b_ff, b_in, q_ff, q_in, r_ff, r_in;
   logic [XLEN-1:0] acc_ff, acc_in, prod_ff, prod_in;
   logic [XLEN:0]   r_shift, r_diff;
   logic [HW-1:0]   mx, my;
   logic            last;

   always_comb begin
      r_shift = {r_ff, q_ff[XLEN-1]};
      r_diff  = r_shift - {1'b0, b_ff};
      // step 0: lo*lo, step 1: lo(a)*hi(b), step 2: hi(a)*lo(b)
      mx      = (cnt_ff == CW'(2)) ? a_ff[XLEN-1:HW] : a_ff[HW-1:0];
      my      = (cnt_ff == CW'(1)) ? b_ff[XLEN-1:HW] : b_ff[HW-1:0];
      prod_in = mx * my;
      last    = div_ff ? (cnt_ff == CW'(XLEN - 1)) : (cnt_ff == CW'(3));

      run_in  = run_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      acc_in  = acc_ff;

      if (ctrl.start) begin
         run_in = 1'b1;
         div_in = ctrl.is_div;
         cnt_in = '0;
         a_in   = opa;
         b_in   = opb;
         q_in   = opa;
         r_in   = '0;
         acc_in = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + CW'(1);
         if (div_ff) begin
            if (!r_diff[XLEN]) begin
               r_in = r_diff[XLEN-1:0];
               q_in = {q_ff[XLEN-2:0], 1'b1};
            end else begin
               r_in = r_shift[XLEN-1:0];
               q_in = {q_ff[XLEN-2:0], 1'b0};
            end
         end else if (cnt_ff == CW'(1)) begin
            acc_in = prod_ff;
         end else if (cnt_ff != '0) begin
            acc_in = acc_ff + {prod_ff[HW-1:0], {HW{1'b0}}};
         end
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         div_ff  <= div_in;
         cnt_ff  <= cnt_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule
